FILE: src/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GCSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("implication check failed");

// Next-cycle implication.
`define GCSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

// Delayed implication.
`define GCSP_ASSERT_DLY2(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
	else $error("two-cycle check failed");

`endif

FILE: src/gcsp_pkg.sv
// ----------------------------------------------------------------------------
// gcsp_pkg
// Types and constants of the game controller serial port pair.
// ----------------------------------------------------------------------------
package gcsp_pkg;

	typedef enum logic [1:0] {
		OP_STROBE = 2'd0,
		OP_READ   = 2'd1,
		OP_LATCH  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		REG_VENDING  = 3'd0,
		REG_FOUR     = 3'd1,
		REG_PORT0    = 3'd2,
		REG_PORT1    = 3'd3,
		REG_DIP      = 3'd4
	} cfg_index_t;

	localparam int unsigned POS_W = 5;
	localparam logic [POS_W-1:0] POS_MAX = 5'd31;
	localparam logic [POS_W-1:0] SIG_POS = 5'd19;
	localparam logic [7:0] BUS_MASK = 8'hC0;
	localparam logic [7:0] DIP_HI_MASK = 8'hFC;
	localparam logic [7:0] COIN_BIT = 8'h04;

	typedef struct packed {
		opcode_t    opcode;
		logic       port_select;
		logic       strobe_bit;
		logic [1:0] bus_high_bits;
		logic       coin_active;
		logic [7:0] pad_one;
		logic [7:0] pad_two;
		logic [7:0] pad_three;
		logic [7:0] pad_four;
	} item_t;

	typedef struct packed {
		logic       we;
		cfg_index_t index;
		logic [7:0] data;
	} cfg_wr_t;

endpackage

FILE: src/gcsp_core.sv
// ----------------------------------------------------------------------------
// gcsp_core
// Port state, configuration registers and the read logic for one item.
// ----------------------------------------------------------------------------
module gcsp_core import gcsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_wr_t    cfg,
	input  logic       fire,
	input  item_t      item,
	output logic [7:0] result
);

	logic                 vending_q;
	logic                 four_q;
	logic                 port0_q;
	logic                 port1_q;
	logic [7:0]           dip_q;
	logic [POS_W-1:0]     pos_q [2];
	logic                 prev_strobe_q;
	logic [7:0]           pad_q [4];

	logic                 w;
	logic [POS_W-1:0]     p;
	logic                 present;
	logic [1:0]           pad_idx;
	logic                 pad_bit;
	logic                 std_b;
	logic                 advance;
	logic [POS_W-1:0]     p_inc;
	logic                 rewind;

	always_comb begin
		w       = item.port_select;
		p       = pos_q[w];
		present = w ? port1_q : port0_q;
		pad_idx = {(p >= 5'd8) && !vending_q, w};
		pad_bit = pad_q[pad_idx][p[2:0]];
		p_inc   = (p == POS_MAX) ? POS_MAX : p + 5'd1;
		std_b   = (p >= 5'd16) ? 1'b0 : pad_bit;
		if (!four_q) begin
			if (p >= 5'd8) begin
				std_b = 1'b1;
			end
		end else if (p == SIG_POS - {4'd0, w}) begin
			std_b = 1'b1;
		end
		result  = 8'd0;
		advance = 1'b0;
		rewind  = 1'b0;
		unique case (item.opcode)
			OP_STROBE: begin
				rewind = prev_strobe_q && !item.strobe_bit;
			end
			OP_READ: begin
				if (vending_q) begin
					if (present) begin
						if (p < 5'd8) begin
							result[0] = pad_bit;
							advance   = 1'b1;
						end else begin
							result[0] = 1'b1;
						end
					end
					if (!w) begin
						result[4:3] = dip_q[1:0];
						if (item.coin_active) begin
							result = result | COIN_BIT;
						end
					end else begin
						result = result | (dip_q & DIP_HI_MASK);
					end
				end else begin
					if (present) begin
						result[0] = std_b;
						advance   = 1'b1;
					end
					result[7:6] = item.bus_high_bits;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vending_q <= 1'b0;
			four_q    <= 1'b0;
			port0_q   <= 1'b1;
			port1_q   <= 1'b1;
			dip_q     <= 8'd0;
		end else if (cfg.we) begin
			unique case (cfg.index)
				REG_VENDING: vending_q <= cfg.data[0];
				REG_FOUR:    four_q    <= cfg.data[0];
				REG_PORT0:   port0_q   <= cfg.data[0];
				REG_PORT1:   port1_q   <= cfg.data[0];
				REG_DIP:     dip_q     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q[0]      <= '0;
			pos_q[1]      <= '0;
			prev_strobe_q <= 1'b0;
			pad_q[0]      <= 8'd0;
			pad_q[1]      <= 8'd0;
			pad_q[2]      <= 8'd0;
			pad_q[3]      <= 8'd0;
		end else if (fire) begin
			if (item.opcode == OP_STROBE) begin
				prev_strobe_q <= item.strobe_bit;
			end
			if (rewind) begin
				pos_q[0] <= '0;
				pos_q[1] <= '0;
			end else if (advance) begin
				pos_q[w] <= p_inc;
			end
			if (item.opcode == OP_LATCH) begin
				pad_q[0] <= item.pad_one;
				pad_q[1] <= item.pad_two;
				pad_q[2] <= item.pad_three;
				pad_q[3] <= item.pad_four;
			end
		end
	end

endmodule

FILE: src/game_controller_serial_port.sv
// ----------------------------------------------------------------------------
// game_controller_serial_port
// Two serially read controller ports with four-player and coin-op formats.
// ----------------------------------------------------------------------------
// One beat is taken per clock while the output is not stalled. A beat is
// registered at the input and evaluated against the port state in the cycle
// in which its byte is loaded into the output register, which happens as soon
// as the output is free. While a result waits on out_ready, the input register
// takes one more beat and then holds in_ready low until the result moves. The
// rate is one beat per cycle while out_ready is high. There is no clearing
// pass after reset.
module game_controller_serial_port import gcsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic       port_select,
	input  logic       strobe_bit,
	input  logic [1:0] bus_high_bits,
	input  logic       coin_active,
	input  logic [7:0] pad_one,
	input  logic [7:0] pad_two,
	input  logic [7:0] pad_three,
	input  logic [7:0] pad_four,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data
);

	logic       valid_s1;
	item_t      item_s1;
	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic       adv;
	logic [7:0] result;
	cfg_wr_t    cfg;

	assign cfg.we    = cfg_write;
	assign cfg.index = cfg_index_t'(cfg_index);
	assign cfg.data  = cfg_data;

	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.opcode        <= opcode_t'(opcode);
			item_s1.port_select   <= port_select;
			item_s1.strobe_bit    <= strobe_bit;
			item_s1.bus_high_bits <= bus_high_bits;
			item_s1.coin_active   <= coin_active;
			item_s1.pad_one       <= pad_one;
			item_s1.pad_two       <= pad_two;
			item_s1.pad_three     <= pad_three;
			item_s1.pad_four      <= pad_four;
		end
	end

	gcsp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (adv),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_q <= result;
		end
	end

endmodule

FILE: src/gcsp_checker.sv
// ----------------------------------------------------------------------------
// gcsp_checker
// Port-level checks of the game controller serial port, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] read_data
);

	// A stalled result keeps its byte.
	`GCSP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(read_data))

	// The input only stalls when a result is blocked at the output.
	`GCSP_ASSERT_IMP(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready)

	// Every accepted beat is followed by a result waiting at the output.
	`GCSP_ASSERT_DLY2(a_latency, clk, arst_n, in_valid && in_ready, out_valid)

endmodule

bind game_controller_serial_port gcsp_checker u_gcsp_checker (.*);

FILE: test/game_controller_serial_port_tb.sv
// ----------------------------------------------------------------------------
// game_controller_serial_port_tb
// Self-checking bench for the serial controller port pair.
//
// Each beat the block accepts is run through a cycle-free model of both
// ports. The model covers read positions, strobe edges, latched pads, the
// four-player signature and the coin-op format. The byte it predicts is
// queued and compared with the next byte the block returns. Stimulus starts
// with a short directed run. Random latch, strobe and read frames follow,
// under several port settings, with random gaps on both channels, one long
// output stall and several full drains.
// ----------------------------------------------------------------------------
module game_controller_serial_port_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gcsp_pkg::*;

	class serial_port_model;
		logic vending;
		logic four_port;
		logic port0_on;
		logic port1_on;
		logic [7:0] dip;
		logic [POS_W-1:0] position [2];
		logic strobe_seen;
		logic [7:0] pads [4];
		logic [7:0] pending_bytes [$];
		int failures;
		int reported;

		function new();
			vending = 1'b0;
			four_port = 1'b0;
			port0_on = 1'b1;
			port1_on = 1'b1;
			dip = 8'h00;
			position[0] = '0;
			position[1] = '0;
			strobe_seen = 1'b0;
			for (int i = 0; i < 4; i++) begin
				pads[i] = 8'h00;
			end
			failures = 0;
			reported = 0;
		endfunction

		function void set_reg(cfg_index_t idx, logic [7:0] value);
			case (idx)
				REG_VENDING: vending = value[0];
				REG_FOUR: four_port = value[0];
				REG_PORT0: port0_on = value[0];
				REG_PORT1: port1_on = value[0];
				REG_DIP: dip = value;
				default: ;
			endcase
		endfunction

		function logic [POS_W-1:0] advance(logic [POS_W-1:0] p);
			return (p == POS_MAX) ? p : p + 1'b1;
		endfunction

		function logic [7:0] read_byte(item_t b);
			logic [7:0] r;
			logic w;
			logic present;
			logic bit_out;
			logic [POS_W-1:0] p;
			r = 8'h00;
			case (b.opcode)
				OP_STROBE: begin
					if (strobe_seen && !b.strobe_bit) begin
						position[0] = '0;
						position[1] = '0;
					end
					strobe_seen = b.strobe_bit;
				end
				OP_READ: begin
					w = b.port_select;
					present = w ? port1_on : port0_on;
					p = position[w];
					if (vending) begin
						if (present) begin
							if (p < 8) begin
								r[0] = pads[{1'b0, w}][p[2:0]];
								position[w] = advance(p);
							end else begin
								r[0] = 1'b1;
							end
						end
						if (!w) begin
							r = r | {3'b000, dip[1:0], 3'b000};
							if (b.coin_active) begin
								r = r | COIN_BIT;
							end
						end else begin
							r = r | (dip & DIP_HI_MASK);
						end
					end else begin
						if (present) begin
							if (p >= 8) begin
								bit_out = pads[{1'b1, w}][p[2:0]];
							end else begin
								bit_out = pads[{1'b0, w}][p[2:0]];
							end
							if (p >= 16) begin
								bit_out = 1'b0;
							end
							if (!four_port) begin
								if (p >= 8) begin
									bit_out = 1'b1;
								end
							end else if (p == SIG_POS - {4'b0000, w}) begin
								bit_out = 1'b1;
							end
							position[w] = advance(p);
							r[0] = bit_out;
						end
						r = r | ({b.bus_high_bits, 6'b000000} & BUS_MASK);
					end
				end
				OP_LATCH: begin
					pads[0] = b.pad_one;
					pads[1] = b.pad_two;
					pads[2] = b.pad_three;
					pads[3] = b.pad_four;
				end
				default: ;
			endcase
			return r;
		endfunction

		function void take_beat(item_t b);
			pending_bytes.push_back(read_byte(b));
		endfunction

		function void compare_byte(logic [7:0] got);
			logic [7:0] want;
			if (pending_bytes.size() == 0) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("Unexpected beat on the output: read_data %02h", got);
				end
			end else begin
				want = pending_bytes.pop_front();
				if (want !== got) begin
					failures++;
					if (reported < 10) begin
						reported++;
						$display("read_data mismatch: expected %02h, actual %02h", want, got);
					end
				end
			end
		endfunction

		function int pending();
			return pending_bytes.size();
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	cfg_index_t cfg_index = REG_VENDING;
	logic [7:0] cfg_data = 8'h00;
	logic in_valid = 1'b0;
	logic in_ready;
	item_t beat = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] read_data;

	logic steady = 1'b0;
	logic hold_request = 1'b0;
	int hold_left = 0;

	serial_port_model sb = new();

	game_controller_serial_port uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(beat.opcode),
		.port_select(beat.port_select),
		.strobe_bit(beat.strobe_bit),
		.bus_high_bits(beat.bus_high_bits),
		.coin_active(beat.coin_active),
		.pad_one(beat.pad_one),
		.pad_two(beat.pad_two),
		.pad_three(beat.pad_three),
		.pad_four(beat.pad_four),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.take_beat(beat);
			end
			if (out_valid && out_ready) begin
				sb.compare_byte(read_data);
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 300;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= 21);
			end
		end
	end

	initial begin
		#500000;
		$display("game_controller_serial_port test failed");
		$finish;
	end

	function automatic item_t access(opcode_t op, logic port, logic strobe,
			logic [1:0] bus, logic coin);
		item_t b;
		b.opcode = op;
		b.port_select = port;
		b.strobe_bit = strobe;
		b.bus_high_bits = bus;
		b.coin_active = coin;
		b.pad_one = 8'($urandom);
		b.pad_two = 8'($urandom);
		b.pad_three = 8'($urandom);
		b.pad_four = 8'($urandom);
		return b;
	endfunction

	function automatic item_t any_beat(opcode_t op);
		return access(op, 1'($urandom), 1'($urandom), 2'($urandom), 1'($urandom));
	endfunction

	function automatic item_t latch(logic [7:0] a, logic [7:0] b, logic [7:0] c,
			logic [7:0] d);
		item_t it;
		it = any_beat(OP_LATCH);
		it.pad_one = a;
		it.pad_two = b;
		it.pad_three = c;
		it.pad_four = d;
		return it;
	endfunction

	task automatic send(item_t b);
		in_valid <= 1'b1;
		beat <= b;
		do @(posedge clk); while (!in_ready);
		if (!steady && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [7:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic configure(logic vend, logic four, logic p0, logic p1, logic [7:0] dip);
		drain();
		write_reg(REG_VENDING, {7'b0000000, vend});
		write_reg(REG_FOUR, {7'b0000000, four});
		write_reg(REG_PORT0, {7'b0000000, p0});
		write_reg(REG_PORT1, {7'b0000000, p1});
		write_reg(REG_DIP, dip);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pad_value();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic run_phase(int quota);
		int sent;
		int reads;
		int port_mode;
		logic port;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(99) < 12) begin
				send(any_beat(opcode_t'($urandom_range(3))));
				sent++;
			end else begin
				send(latch(pad_value(), pad_value(), pad_value(), pad_value()));
				send(access(OP_STROBE, 1'($urandom), 1'b1, 2'($urandom), 1'($urandom)));
				if ($urandom_range(9) != 0) begin
					send(access(OP_STROBE, 1'($urandom), 1'b0, 2'($urandom), 1'($urandom)));
					sent++;
				end
				reads = ($urandom_range(7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 20);
				port_mode = $urandom_range(2);
				for (int i = 0; i < reads; i++) begin
					port = (port_mode == 2) ? 1'($urandom) : 1'(port_mode);
					send(access(OP_READ, port, 1'($urandom), 2'($urandom), 1'($urandom)));
				end
				sent += 2 + reads;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(access(OP_READ, 1'b0, 1'b0, 2'd3, 1'b0));
		send(latch(8'hA5, 8'h3C, 8'hFF, 8'h00));
		send(access(OP_READ, 1'b0, 1'b1, 2'd0, 1'b1));
		send(access(OP_READ, 1'b1, 1'b0, 2'd3, 1'b1));
		send(access(OP_READ, 1'b0, 1'b0, 2'd1, 1'b0));
		send(access(OP_READ, 1'b1, 1'b1, 2'd2, 1'b0));
		send(access(OP_STROBE, 1'b1, 1'b1, 2'd0, 1'b0));
		send(access(OP_STROBE, 1'b0, 1'b0, 2'd3, 1'b1));
		send(access(OP_STROBE, 1'b1, 1'b0, 2'd0, 1'b0));
		for (int i = 0; i < 10; i++) begin
			send(access(OP_READ, 1'b0, 1'($urandom), 2'(i), 1'($urandom)));
		end
		send(any_beat(OP_NONE));
		send(latch(8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send(access(OP_READ, 1'b1, 1'b0, 2'd0, 1'b0));
		send(latch(8'h00, 8'h00, 8'h00, 8'h00));
		send(access(OP_READ, 1'b1, 1'b1, 2'd3, 1'b1));

		configure(1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
		run_phase(250);
		configure(1'b0, 1'b1, 1'b1, 1'b1, 8'h00);
		run_phase(250);
		configure(1'b1, 1'b0, 1'b1, 1'b1, 8'hFF);
		steady = 1'b1;
		hold_request = 1'b1;
		run_phase(80);
		steady = 1'b0;
		run_phase(170);
		configure(1'b1, 1'b1, 1'b0, 1'b1, 8'hA5);
		run_phase(120);
		drain();
		run_phase(130);
		configure(1'b0, 1'b1, 1'b1, 1'b0, 8'h5A);
		steady = 1'b1;
		run_phase(250);
		steady = 1'b0;
		configure(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
		run_phase(150);
		configure(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
		run_phase(250);
		for (int k = 0; k < 2; k++) begin
			configure(1'($urandom), 1'($urandom), 1'($urandom_range(9) != 0),
				1'($urandom_range(9) != 0), 8'($urandom));
			run_phase(150);
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("game_controller_serial_port test passed");
		end else begin
			$display("game_controller_serial_port test failed");
		end
		$finish;
	end
endmodule
